[src/edacc_pkg.sv]
// Package for the two-channel encoder distance accumulator.
// Holds field widths, register indexes and reset values; no dependencies.
`default_nettype none

package edacc_pkg;

    localparam int unsigned EDACC_COUNTS_PER_REV = 4096;

    localparam int unsigned REV_W    = 16;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned DIST_W   = 64;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Accepted steps lie strictly inside +/- step_limit, so they fit LIMIT_W + 1 signed bits.
    localparam int unsigned STEP_W = LIMIT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_GAIN_CH0 = 3'd0,
        CFG_REV_GAIN_CH0 = 3'd1,
        CFG_FWD_GAIN_CH1 = 3'd2,
        CFG_REV_GAIN_CH1 = 3'd3,
        CFG_INVERT_CH0   = 3'd4,
        CFG_INVERT_CH1   = 3'd5,
        CFG_STEP_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    localparam logic signed [GAIN_W-1:0] FWD_GAIN_CH0_RST = -32'sd5351949;
    localparam logic signed [GAIN_W-1:0] REV_GAIN_CH0_RST = -32'sd5349298;
    localparam logic signed [GAIN_W-1:0] FWD_GAIN_CH1_RST = -32'sd5383205;
    localparam logic signed [GAIN_W-1:0] REV_GAIN_CH1_RST = -32'sd5379178;
    localparam logic                     INVERT_CH0_RST   = 1'b0;
    localparam logic                     INVERT_CH1_RST   = 1'b1;
    localparam logic [LIMIT_W-1:0]       STEP_LIMIT_RST   = 16'd2000;

endpackage

`default_nettype wire

[src/edacc_sample_if.sv]
// Request channel carrying encoder samples and clear requests.
// Depends on edacc_pkg for field widths.
`default_nettype none

interface edacc_sample_if import edacc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic                    channel;
    logic signed [REV_W-1:0] revolutions;
    logic [CNT_W-1:0]        count;

    modport source (output valid, output op, output channel, output revolutions,
                    output count, input ready);
    modport sink   (input valid, input op, input channel, input revolutions,
                    input count, output ready);
endinterface

`default_nettype wire

[src/edacc_result_if.sv]
// Result channel carrying one channel's state after each request.
// Depends on edacc_pkg for field widths.
`default_nettype none

interface edacc_result_if import edacc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     out_channel;
    logic                     accepted;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  total_counts;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, output out_channel, output accepted, output position,
                    output total_counts, output distance, input ready);
    modport sink   (input valid, input out_channel, input accepted, input position,
                    input total_counts, input distance, output ready);
endinterface

`default_nettype wire

[src/encoder_distance_accumulator.sv]
// Two-channel encoder distance accumulator, top level.
// Depends on edacc_pkg, edacc_sample_if and edacc_result_if.
//
// Usage: each request on i_sample is a position sample or a clear for one of two
// channels. A sample forms position = revolutions * COUNTS_PER_REV + count, and
// if the step from the stored position lies strictly inside +/- step_limit, the
// position and total are updated and step * gain * direction is added to the
// Q40.24 distance. Each request yields exactly one result on o_result with the
// channel's state after the request.
// The position is formed into an input register, and the window check, gain
// multiply and accumulate then run from it into the result register.
// Throughput is one request per cycle while the receiver takes results, also
// for back-to-back requests on the same channel, since the per-channel state
// registers are read and written in the same cycle.
// When the receiver stalls, the input register still takes one more request;
// ready drops only while both registers are full. Reset restores the register
// defaults and clears all channel state; the block is ready for requests as
// soon as reset is released. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_wdata; the user must write it only while no request is
// in flight, as the block itself does not enforce this.
`default_nettype none

module encoder_distance_accumulator import edacc_pkg::*; #(
    parameter int unsigned COUNTS_PER_REV = EDACC_COUNTS_PER_REV
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    edacc_sample_if.sink               i_sample,
    edacc_result_if.source             o_result
);

    localparam logic signed [POS_W:0] CPR_S = (POS_W + 1)'(COUNTS_PER_REV);

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_fwd_gain [2];
    logic signed [GAIN_W-1:0] r_rev_gain [2];
    logic                     r_invert   [2];
    logic [LIMIT_W-1:0]       r_step_limit;

    // Per-channel state.
    logic [POS_W-1:0]  r_pos   [2];
    logic [POS_W-1:0]  r_mark  [2];
    logic [POS_W-1:0]  r_total [2];
    logic [DIST_W-1:0] r_dist  [2];

    // Input register.
    logic             r_in_valid;
    logic             r_in_op;
    logic             r_in_ch;
    logic [POS_W-1:0] r_in_pos;

    // Result register.
    logic              r_out_valid;
    logic              r_out_ch;
    logic              r_out_acc;
    logic [POS_W-1:0]  r_out_pos;
    logic [POS_W-1:0]  r_out_total;
    logic [DIST_W-1:0] r_out_dist;

    logic w_adv;
    logic w_in_take;
    logic w_fire;

    logic signed [POS_W:0]    w_rev_x;
    logic signed [POS_W:0]    w_rev_prod;
    logic [POS_W-1:0]         n_in_pos;

    logic [POS_W-1:0]           w_step;
    logic signed [POS_W:0]      w_step_x;
    logic signed [POS_W:0]      w_lim_x;
    logic                       w_in_window;
    logic signed [GAIN_W-1:0]   w_gain;
    logic signed [STEP_W+GAIN_W-1:0] w_mul;
    logic [DIST_W-1:0]          w_inc;

    logic              n_acc;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  n_mark;
    logic [POS_W-1:0]  n_total;
    logic [DIST_W-1:0] n_dist;

    assign w_adv     = !r_out_valid || o_result.ready;
    assign w_fire    = r_in_valid && w_adv;
    assign w_in_take = i_sample.valid && i_sample.ready;
    assign i_sample.ready = !r_in_valid || w_adv;

    // Absolute position of the new sample, wrapped to 32 bits.
    always_comb begin
        w_rev_x    = (POS_W + 1)'(i_sample.revolutions);
        w_rev_prod = w_rev_x * CPR_S;
        n_in_pos   = w_rev_prod[POS_W-1:0] + POS_W'(i_sample.count);
    end

    // Window check, gain multiply and accumulate for the item in the input register.
    always_comb begin
        w_step      = r_in_pos - r_pos[r_in_ch];
        w_step_x    = (POS_W + 1)'($signed(w_step));
        w_lim_x     = (POS_W + 1)'($signed({1'b0, r_step_limit}));
        w_in_window = (w_step_x < w_lim_x) && (w_step_x > -w_lim_x);
        w_gain      = w_step[POS_W-1] ? r_rev_gain[r_in_ch] : r_fwd_gain[r_in_ch];
        // Only the low bits of the step matter once it lies inside the window.
        w_mul       = $signed(w_step[STEP_W-1:0]) * w_gain;
        w_inc       = DIST_W'(w_mul);

        n_acc   = 1'b0;
        n_pos   = r_pos[r_in_ch];
        n_mark  = r_mark[r_in_ch];
        n_total = r_total[r_in_ch];
        n_dist  = r_dist[r_in_ch];
        case (t_op'(r_in_op))
            OP_CLEAR: begin
                n_acc   = 1'b1;
                n_mark  = r_pos[r_in_ch];
                n_total = '0;
                n_dist  = '0;
            end
            OP_SAMPLE: begin
                if (w_in_window) begin
                    n_acc   = 1'b1;
                    n_pos   = r_in_pos;
                    n_total = r_in_pos - r_mark[r_in_ch];
                    n_dist  = r_invert[r_in_ch] ? (r_dist[r_in_ch] - w_inc)
                                                : (r_dist[r_in_ch] + w_inc);
                end
            end
            default: begin
                n_acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_gain[0] <= FWD_GAIN_CH0_RST;
            r_rev_gain[0] <= REV_GAIN_CH0_RST;
            r_fwd_gain[1] <= FWD_GAIN_CH1_RST;
            r_rev_gain[1] <= REV_GAIN_CH1_RST;
            r_invert[0]   <= INVERT_CH0_RST;
            r_invert[1]   <= INVERT_CH1_RST;
            r_step_limit  <= STEP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FWD_GAIN_CH0: r_fwd_gain[0] <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_REV_GAIN_CH0: r_rev_gain[0] <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_FWD_GAIN_CH1: r_fwd_gain[1] <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_REV_GAIN_CH1: r_rev_gain[1] <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_INVERT_CH0:   r_invert[0]   <= i_cfg_wdata[0];
                CFG_INVERT_CH1:   r_invert[1]   <= i_cfg_wdata[0];
                CFG_STEP_LIMIT:   r_step_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_pos[c]   <= '0;
                r_mark[c]  <= '0;
                r_total[c] <= '0;
                r_dist[c]  <= '0;
            end
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= w_in_take;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_pos[r_in_ch]   <= n_pos;
                r_mark[r_in_ch]  <= n_mark;
                r_total[r_in_ch] <= n_total;
                r_dist[r_in_ch]  <= n_dist;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op  <= i_sample.op;
            r_in_ch  <= i_sample.channel;
            r_in_pos <= n_in_pos;
        end
        if (w_fire) begin
            r_out_ch    <= r_in_ch;
            r_out_acc   <= n_acc;
            r_out_pos   <= n_pos;
            r_out_total <= n_total;
            r_out_dist  <= n_dist;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_channel  = r_out_ch;
    assign o_result.accepted     = r_out_acc;
    assign o_result.position     = $signed(r_out_pos);
    assign o_result.total_counts = $signed(r_out_total);
    assign o_result.distance     = $signed(r_out_dist);

`ifndef NO_ASSERTIONS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_op == OP_CLEAR |=>
            r_out_acc && r_out_dist == '0 && r_out_total == '0)
        else $error("clear request did not zero distance and total");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_op == OP_SAMPLE && !w_in_window |=>
            !r_out_acc && r_pos[r_out_ch] == $past(r_pos[r_in_ch])
            && r_dist[r_out_ch] == $past(r_dist[r_in_ch]))
        else $error("rejected sample changed channel state");

    a_accept_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_op == OP_SAMPLE && w_in_window |=>
            r_out_acc && r_out_pos == $past(r_in_pos)
            && r_out_total == r_out_pos - r_mark[r_out_ch])
        else $error("accepted sample position or total is wrong");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> r_in_valid && r_out_valid && !o_result.ready)
        else $error("input stalled while a register stage was free");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the two-channel encoder distance accumulator.
// Depends on edacc_pkg, edacc_sample_if, edacc_result_if and the top level in src.
// A directed table runs first, then random samples and clears under several register settings.

module testbench;
    import edacc_pkg::*;

    localparam int CPR_I = int'(EDACC_COUNTS_PER_REV);

    typedef struct {
        t_op                     op;
        logic                    ch;
        logic signed [REV_W-1:0] rev;
        logic [CNT_W-1:0]        cnt;
    } t_odo_request;

    typedef struct {
        logic                     ch;
        logic                     acc;
        logic signed [POS_W-1:0]  pos;
        logic signed [POS_W-1:0]  tot;
        logic signed [DIST_W-1:0] distance;
    } t_odo_result;

    typedef struct {
        t_odo_request rq;
        bit           typed;
        t_odo_result  res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    edacc_sample_if smp ();
    edacc_result_if res ();

    encoder_distance_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (smp),
        .o_result    (res)
    );

    // Tracked copy of the per-channel odometry state and the registers.
    logic signed [POS_W-1:0]  trk_pos   [2];
    logic signed [POS_W-1:0]  trk_mark  [2];
    logic signed [POS_W-1:0]  trk_total [2];
    logic signed [DIST_W-1:0] trk_dist  [2];
    logic signed [GAIN_W-1:0] m_fwd_gain [2];
    logic signed [GAIN_W-1:0] m_rev_gain [2];
    logic                     m_invert   [2];
    logic [LIMIT_W-1:0]       m_step_limit;

    t_odo_result pending_results [$];
    t_dir_row    directed_rows [15];

    int idle_pct   = 34;
    int mismatches = 0;
    int n_taken    = 0;
    int n_glitch   = 0;
    int n_clear    = 0;
    int n_settings = 1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    function automatic t_odo_result advance_odometer(t_odo_request rq);
        t_odo_result              r;
        logic [POS_W-1:0]         now;
        logic [POS_W-1:0]         diff;
        logic signed [GAIN_W-1:0] g;
        longint                   posw;
        longint                   step;
        longint                   lim;
        longint                   incr;
        r.acc = 1'b0;
        if (rq.op == OP_CLEAR) begin
            trk_dist[rq.ch]  = '0;
            trk_mark[rq.ch]  = trk_pos[rq.ch];
            trk_total[rq.ch] = '0;
            r.acc = 1'b1;
            n_clear++;
        end else begin
            posw = longint'(rq.rev) * longint'(CPR_I) + longint'(rq.cnt);
            now  = posw[POS_W-1:0];
            diff = now - trk_pos[rq.ch];
            step = longint'(signed'(diff));
            lim  = longint'(m_step_limit);
            // The window is open on both ends; a limit of zero rejects everything.
            if (step < lim && step > -lim) begin
                g = (step >= 0) ? m_fwd_gain[rq.ch] : m_rev_gain[rq.ch];
                incr = step * longint'(g);
                if (m_invert[rq.ch]) begin
                    incr = -incr;
                end
                trk_pos[rq.ch]   = now;
                trk_total[rq.ch] = now - trk_mark[rq.ch];
                trk_dist[rq.ch]  = trk_dist[rq.ch] + incr;
                r.acc = 1'b1;
                n_taken++;
            end else begin
                n_glitch++;
            end
        end
        r.ch       = rq.ch;
        r.pos      = trk_pos[rq.ch];
        r.tot      = trk_total[rq.ch];
        r.distance = trk_dist[rq.ch];
        return r;
    endfunction

    // Mostly plausible next samples near the tracked position, some right at the
    // window edges, plus clears and samples with arbitrary field contents.
    function automatic t_odo_request make_request();
        t_odo_request rq;
        int           pick;
        int           lim;
        int           delta;
        int           target;
        int           q;
        int           rem;
        pick     = int'($urandom_range(99));
        rq.ch    = 1'($urandom);
        rq.rev   = 16'($urandom);
        rq.cnt   = 16'($urandom);
        rq.op    = OP_SAMPLE;
        if (pick < 10) begin
            rq.op = OP_CLEAR;
        end else if (pick >= 25) begin
            lim = int'(m_step_limit);
            if (lim == 0) begin
                delta = int'($urandom_range(3));
            end else if ($urandom_range(9) == 0) begin
                delta = ($urandom_range(1) == 0) ? lim - 1 : lim;
            end else begin
                delta = int'($urandom_range(lim - 1, 0));
            end
            if ($urandom_range(1) == 1) begin
                delta = -delta;
            end
            target = int'(trk_pos[rq.ch]) + delta;
            q   = target / CPR_I;
            rem = target - q * CPR_I;
            if (rem < 0) begin
                q--;
                rem += CPR_I;
            end
            if ($urandom_range(3) == 0 && q > -32768) begin
                // Same position, spelled with a count of one revolution or more.
                q--;
                rem += CPR_I;
            end
            if (q < -32768 || q > 32767) begin
                q   = 0;
                rem = 0;
            end
            rq.rev = 16'(q);
            rq.cnt = 16'(rem);
        end
        return rq;
    endfunction

    task automatic offer_request(t_odo_request rq, bit typed, t_odo_result typed_res);
        t_odo_result p;
        while ($urandom_range(99) < idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid       <= 1'b1;
        smp.op          <= rq.op;
        smp.channel     <= rq.ch;
        smp.revolutions <= rq.rev;
        smp.count       <= rq.cnt;
        do @(posedge i_clk); while (smp.ready !== 1'b1);
        p = advance_odometer(rq);
        pending_results.push_back(typed ? typed_res : p);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_FWD_GAIN_CH0: m_fwd_gain[0] = value;
            CFG_REV_GAIN_CH0: m_rev_gain[0] = value;
            CFG_FWD_GAIN_CH1: m_fwd_gain[1] = value;
            CFG_REV_GAIN_CH1: m_rev_gain[1] = value;
            CFG_INVERT_CH0:   m_invert[0]   = value[0];
            CFG_INVERT_CH1:   m_invert[1]   = value[0];
            CFG_STEP_LIMIT:   m_step_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_setting(int phase);
        logic [GAIN_W-1:0]  fg [2];
        logic [GAIN_W-1:0]  rg [2];
        logic               inv [2];
        logic [LIMIT_W-1:0] lim;
        for (int c = 0; c < 2; c++) begin
            fg[c]  = $urandom;
            rg[c]  = $urandom;
            inv[c] = 1'($urandom);
        end
        case (phase)
            0: begin
                fg  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF};
                rg  = '{32'h8000_0000, 32'h8000_0000};
                inv = '{1'b1, 1'b0};
                lim = 16'hFFFF;
            end
            1: begin
                fg  = '{32'h8000_0000, 32'h8000_0000};
                rg  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF};
                inv = '{1'b0, 1'b1};
                lim = 16'd1;
            end
            2: begin
                fg  = '{FWD_GAIN_CH0_RST, FWD_GAIN_CH1_RST};
                rg  = '{REV_GAIN_CH0_RST, REV_GAIN_CH1_RST};
                inv = '{INVERT_CH0_RST, INVERT_CH1_RST};
                lim = STEP_LIMIT_RST;
            end
            3: lim = 16'd0;
            4: lim = 16'($urandom_range(64, 2));
            5: lim = 16'($urandom_range(5000, 100));
            6: lim = 16'($urandom_range(65535, 1));
            default: lim = 16'd2000;
        endcase
        write_reg(CFG_FWD_GAIN_CH0, fg[0]);
        write_reg(CFG_REV_GAIN_CH0, rg[0]);
        write_reg(CFG_FWD_GAIN_CH1, fg[1]);
        write_reg(CFG_REV_GAIN_CH1, rg[1]);
        write_reg(CFG_INVERT_CH0, 32'(inv[0]));
        write_reg(CFG_INVERT_CH1, 32'(inv[1]));
        write_reg(CFG_STEP_LIMIT, 32'(lim));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random back-pressure, with two long hold-offs so the block fills up.
    initial begin
        int          hold_left;
        int          seen;
        t_odo_result want;
        hold_left = 0;
        seen      = 0;
        res.ready = 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(negedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                seen++;
                if (seen == 300 || seen == 1100) begin
                    hold_left = 60;
                end
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing pending: channel %0d, position %0d",
                             $time, res.out_channel, res.position);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("channel", 64'(want.ch), 64'(res.out_channel));
                    check_field("accepted", 64'(want.acc), 64'(res.accepted));
                    check_field("position", want.pos, res.position);
                    check_field("total_counts", want.tot, res.total_counts);
                    check_field("distance", want.distance, res.distance);
                end
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else begin
                res.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin
        t_odo_result none_typed;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_FWD_GAIN_CH0;
        i_cfg_wdata     = '0;
        smp.valid       = 1'b0;
        smp.op          = OP_SAMPLE;
        smp.channel     = 1'b0;
        smp.revolutions = '0;
        smp.count       = '0;
        none_typed      = '{1'b0, 1'b0, 32'sd0, 32'sd0, 64'sd0};

        m_fwd_gain   = '{FWD_GAIN_CH0_RST, FWD_GAIN_CH1_RST};
        m_rev_gain   = '{REV_GAIN_CH0_RST, REV_GAIN_CH1_RST};
        m_invert     = '{INVERT_CH0_RST, INVERT_CH1_RST};
        m_step_limit = STEP_LIMIT_RST;
        trk_pos      = '{32'sd0, 32'sd0};
        trk_mark     = '{32'sd0, 32'sd0};
        trk_total    = '{32'sd0, 32'sd0};
        trk_dist     = '{64'sd0, 64'sd0};

        // Typed expectations hold only for the reset register values.
        directed_rows = '{
            '{'{OP_CLEAR,  1'b0,  16'sd0,     16'd0},     1'b1,
              '{1'b0, 1'b1,  32'sd0,     32'sd0,  64'sd0}},
            '{'{OP_SAMPLE, 1'b0,  16'sd0,     16'd0},     1'b1,
              '{1'b0, 1'b1,  32'sd0,     32'sd0,  64'sd0}},
            '{'{OP_SAMPLE, 1'b1,  16'sd1,     16'd0},     1'b1,
              '{1'b1, 1'b0,  32'sd0,     32'sd0,  64'sd0}},
            '{'{OP_SAMPLE, 1'b1, -16'sd1,     16'd4095},  1'b1,
              '{1'b1, 1'b1, -32'sd1,    -32'sd1, -64'sd5379178}},
            '{'{OP_SAMPLE, 1'b0,  16'sd0,     16'd1999},  1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0,  16'sd0,     16'd3999},  1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0, -16'sd1,     16'd6100},  1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0,  16'sd0,     16'd4},     1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0,  16'sd0,     16'd5},     1'b0, none_typed},
            '{'{OP_CLEAR,  1'b1,  16'sd0,     16'd0},     1'b1,
              '{1'b1, 1'b1, -32'sd1,     32'sd0,  64'sd0}},
            '{'{OP_SAMPLE, 1'b1, -16'sd1,     16'd4098},  1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0,  16'sd32767, 16'd65535}, 1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b0, -16'sd32768, 16'd0},     1'b0, none_typed},
            '{'{OP_SAMPLE, 1'b1, -16'sd32768, 16'd65535}, 1'b0, none_typed},
            '{'{OP_CLEAR,  1'b0,  16'sd0,     16'd0},     1'b0, none_typed}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
        end
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            apply_setting(phase);
            // One setting runs with no idling on either side.
            idle_pct = (phase == 2) ? 0 : 34;
            repeat (200) begin
                offer_request(make_request(), 1'b0, none_typed);
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d requests across %0d register settings, window limits 0 to 65535.",
                 n_taken + n_glitch + n_clear, n_settings);
        $display("Samples taken: %0d, rejected as glitches: %0d, clears: %0d.",
                 n_taken, n_glitch, n_clear);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/edacc_pkg.sv
src/edacc_sample_if.sv
src/edacc_result_if.sv
src/encoder_distance_accumulator.sv
dv/testbench.sv
